// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the timed event queue.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/teq_pkg.sv =====
// Package of the timed event queue: widths, request codes and defaults.
// Depends on nothing.
package teq_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NS_PER_CLOCK_DEF = 40;
    localparam int MAX_RUN_TICKS_DEF = 125000;
    localparam int RUN_W = 17;
    localparam logic [63:0] NS_PER_SEC = 64'd1000000000;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_SCHED = 2'd1,
        REQ_IDLE = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    localparam logic CFG_WD_ENABLE = 1'b0;
    localparam logic CFG_WD_TIMEOUT = 1'b1;

    localparam logic [1:0] WD_NONE = 2'd0;
    localparam logic [1:0] WD_CAUTION = 2'd1;
    localparam logic [1:0] WD_LETHAL = 2'd2;

    // One slot of the event table.
    typedef struct packed {
        logic [63:0] due;
        logic [31:0] code;
        logic [15:0] tag;
    } slot_t;
endpackage

// ===== rtl/teq_slot_ram.sv =====
// Event table memory: one write port, one registered read port.
// Depends on teq_pkg.
module teq_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  teq_pkg::slot_t    wdata,
    input  logic [AW-1:0]     raddr,
    output teq_pkg::slot_t    rdata
);
    import teq_pkg::*;
    slot_t mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/timed_event_queue_with_watchdog.sv =====
// Top level of the timed event queue with a no-progress watchdog.
// Depends on teq_pkg, teq_slot_ram and assert_macros.svh.
//
//  channel   | dir | contents
//  s_axis    | in  | tdata: req_type, tick_count, progress_seen, advance_nsecs,
//            |     |        delay_nsecs, event_code, event_tag
//  m_axis    | out | tdata: fired_code, fired_tag, run_ticks, stop_cpu, queue_full,
//            |     |        watchdog_status; tuser: event_fired; tlast: last
//  cfg       | in  | wr_en, wr_index, wr_data
//
// One request at a time. The table sits in one memory with one read and one write port.
// An insert compares slots one a cycle, then moves each later slot up one place a cycle.
// An advance fires each due event at the head and then moves every remaining event down
// one place. The run length comes from a registered reciprocal multiply. Reset is
// synchronous; a stalled result holds the block.
module timed_event_queue_with_watchdog #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    parameter int NS_PER_CLOCK = teq_pkg::NS_PER_CLOCK_DEF,
    parameter int MAX_RUN_TICKS = teq_pkg::MAX_RUN_TICKS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[1:0], tick_count[33:2], progress_seen[34], advance_nsecs[66:35],
    // delay_nsecs[98:67], event_code[130:99], event_tag[146:131], zero fill
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fired_code[31:0], fired_tag[47:32], run_ticks[64:48], stop_cpu[65],
    // queue_full[66], watchdog_status[68:67], zero fill
    output logic [71:0]  m_axis_tdata,
    // event_fired[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         wr_en,
    input  logic         wr_index,
    input  logic [15:0]  wr_data
);
    import teq_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [63:0] SPAN = 64'(MAX_RUN_TICKS) * 64'(NS_PER_CLOCK);
    localparam logic [63:0] NSC = 64'(NS_PER_CLOCK);
    // Reciprocal of the clock period; exact for dividends below 2^31.
    localparam int DIV_SH = 31 + $clog2(NS_PER_CLOCK);
    localparam logic [63:0] RECIP = ((64'd1 << DIV_SH) + NSC - 64'd1) / NSC;

    localparam logic [1:0] PH_DECIDE = 2'd0;
    localparam logic [1:0] PH_MUL = 2'd1;
    localparam logic [1:0] PH_SEND = 2'd2;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_ADV    = 12'b000000000010,
        ST_HEAD   = 12'b000000000100,
        ST_HCHK   = 12'b000000001000,
        ST_FIRE   = 12'b000000010000,
        ST_SHDN   = 12'b000000100000,
        ST_SRCH   = 12'b000001000000,
        ST_SCMP   = 12'b000010000000,
        ST_SHUP   = 12'b000100000000,
        ST_WDOG   = 12'b001000000000,
        ST_RUN    = 12'b010000000000,
        ST_DIV    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [63:0] vt_reg, deadline_reg;
    logic [CW-1:0] count_reg;
    logic promised_reg, warned_reg, wd_en_reg;
    logic [15:0] timeout_reg;
    req_t req_reg;
    logic [31:0] ticks_reg, adv_reg;
    logic progress_reg;
    slot_t new_reg;
    logic [63:0] prod_reg;
    logic [AW-1:0] ptr_reg;
    logic [CW-1:0] pos_reg;
    logic stop_reg, full_reg;
    logic [1:0] wd_reg;
    logic [30:0] rem_reg;
    logic [RUN_W-1:0] quo_reg;
    logic [1:0] phase_reg;
    logic out_valid_reg;
    logic [71:0] out_data_reg;
    logic out_user_reg, out_last_reg;
    logic out_load;
    logic [62:0] run_prod;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    slot_t ram_wdata, ram_rdata;

    teq_slot_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // Deadline renewal: the seconds product is formed as 16 by 30 bits.
    logic [63:0] timeout_ns;
    assign timeout_ns = 64'(timeout_reg) * NS_PER_SEC;

    // Rounded-up run length as a multiply by the reciprocal of the period.
    assign run_prod = 63'(rem_reg) * 63'(RECIP[31:0]);

    // A result register load happens when it is free or being emptied.
    assign out_load = (m_axis_tready || !out_valid_reg) &&
                      (state_reg == ST_FIRE || (state_reg == ST_DIV && phase_reg == PH_SEND));

    // Control and memory address logic.
    always_comb begin
        state_next = state_reg;
        ram_we = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = ptr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = '0;
                if (s_axis_tvalid && s_axis_tready) begin
                    unique case (req_t'(s_axis_tdata[1:0]))
                        REQ_TICK, REQ_IDLE: state_next = ST_ADV;
                        REQ_SCHED: state_next = ST_SRCH;
                        default: state_next = ST_RUN;
                    endcase
                end
            end
            ST_ADV: state_next = ST_HEAD;
            ST_HEAD: begin
                ram_raddr = '0;
                state_next = ST_HCHK;
            end
            ST_HCHK: begin
                if (count_reg != '0 && ram_rdata.due <= vt_reg) begin
                    state_next = ST_FIRE;
                end else begin
                    state_next = (req_reg == REQ_TICK) ? ST_WDOG : ST_RUN;
                end
            end
            ST_FIRE: begin
                if (m_axis_tready || !out_valid_reg) begin
                    ram_raddr = AW'(1);
                    state_next = ST_SHDN;
                end
            end
            ST_SHDN: begin
                // ptr points at the slot to be written; read slot ptr+2, which the next write needs.
                ram_raddr = ptr_reg + AW'(2);
                if (CW'(ptr_reg) + CW'(1) < count_reg) begin
                    ram_we = 1'b1;
                    ram_waddr = ptr_reg;
                end
                if (CW'(ptr_reg) + CW'(2) >= count_reg) begin
                    state_next = ST_HEAD;
                end
            end
            ST_SRCH: begin
                state_next = (count_reg >= CW'(QUEUE_DEPTH)) ? ST_RUN : ST_SCMP;
            end
            ST_SCMP: begin
                if (pos_reg < count_reg && !(new_reg.due < ram_rdata.due)) begin
                    ram_raddr = ptr_reg + AW'(1);
                end else begin
                    ram_raddr = AW'(count_reg - CW'(1));
                    state_next = ST_SHUP;
                end
            end
            ST_SHUP: begin
                ram_we = 1'b1;
                if (CW'(ptr_reg) + CW'(1) > pos_reg && pos_reg < count_reg &&
                    CW'(ptr_reg) < count_reg) begin
                    ram_waddr = ptr_reg + AW'(1);
                    ram_wdata = ram_rdata;
                    ram_raddr = ptr_reg - AW'(1);
                end else begin
                    // An insert never fires anything; go straight to the run length.
                    ram_waddr = AW'(pos_reg);
                    ram_wdata = new_reg;
                    state_next = ST_RUN;
                end
            end
            ST_WDOG: state_next = ST_RUN;
            ST_RUN: begin
                ram_raddr = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (phase_reg == PH_SEND && (m_axis_tready || !out_valid_reg)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vt_reg <= '0;
            deadline_reg <= '0;
            count_reg <= '0;
            promised_reg <= 1'b0;
            warned_reg <= 1'b0;
            wd_en_reg <= 1'b0;
            timeout_reg <= '0;
            out_valid_reg <= 1'b0;
            phase_reg <= PH_DECIDE;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            // The user must make configuration writes only while idle; the block does not enforce it.
            if (wr_en) begin
                if (wr_index == CFG_WD_ENABLE) begin
                    wd_en_reg <= wr_data[0];
                end else begin
                    timeout_reg <= wr_data;
                    deadline_reg <= vt_reg + 64'(wr_data) * NS_PER_SEC;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    req_reg <= req_t'(s_axis_tdata[1:0]);
                    ticks_reg <= s_axis_tdata[33:2];
                    progress_reg <= s_axis_tdata[34];
                    adv_reg <= s_axis_tdata[66:35];
                    new_reg.due <= vt_reg + 64'(s_axis_tdata[98:67]);
                    new_reg.code <= s_axis_tdata[130:99];
                    new_reg.tag <= s_axis_tdata[146:131];
                    prod_reg <= 64'(s_axis_tdata[33:2]) * NSC;
                    stop_reg <= 1'b0;
                    full_reg <= 1'b0;
                    wd_reg <= WD_NONE;
                    pos_reg <= '0;
                    ptr_reg <= '0;
                end
                ST_ADV: begin
                    vt_reg <= vt_reg + ((req_reg == REQ_TICK) ? prod_reg : 64'(adv_reg));
                end
                ST_HEAD: ptr_reg <= '0;
                ST_HCHK: ;
                ST_FIRE: begin
                    if (m_axis_tready || !out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= {24'd0, ram_rdata.tag, ram_rdata.code};
                        out_user_reg <= 1'b1;
                        out_last_reg <= 1'b0;
                        promised_reg <= 1'b0;
                        ptr_reg <= '0;
                    end
                end
                ST_SHDN: begin
                    ptr_reg <= ptr_reg + AW'(1);
                    if (CW'(ptr_reg) + CW'(2) >= count_reg) begin
                        count_reg <= count_reg - CW'(1);
                    end
                end
                ST_SRCH: begin
                    if (count_reg >= CW'(QUEUE_DEPTH)) begin
                        full_reg <= 1'b1;
                    end
                end
                ST_SCMP: begin
                    if (pos_reg < count_reg && !(new_reg.due < ram_rdata.due)) begin
                        pos_reg <= pos_reg + CW'(1);
                        ptr_reg <= ptr_reg + AW'(1);
                    end else begin
                        ptr_reg <= AW'(count_reg - CW'(1));
                        if (pos_reg == '0 && count_reg != '0 && promised_reg) begin
                            stop_reg <= 1'b1;
                            promised_reg <= 1'b0;
                        end
                    end
                end
                ST_SHUP: begin
                    if (CW'(ptr_reg) + CW'(1) > pos_reg && pos_reg < count_reg &&
                        CW'(ptr_reg) < count_reg) begin
                        ptr_reg <= ptr_reg - AW'(1);
                    end else begin
                        count_reg <= count_reg + CW'(1);
                        req_reg <= REQ_NONE;
                    end
                end
                ST_WDOG: begin
                    if (wd_en_reg) begin
                        if (progress_reg) begin
                            deadline_reg <= vt_reg + timeout_ns;
                            warned_reg <= 1'b0;
                        end else if (vt_reg >= deadline_reg) begin
                            deadline_reg <= vt_reg + timeout_ns;
                            wd_reg <= warned_reg ? WD_LETHAL : WD_CAUTION;
                            warned_reg <= !warned_reg;
                        end
                    end
                end
                ST_RUN: begin
                    quo_reg <= '0;
                    rem_reg <= '0;
                    phase_reg <= PH_DECIDE;
                end
                ST_DIV: begin
                    if (phase_reg == PH_DECIDE) begin
                        // Empty table, head already due, head far away, or head close.
                        if (count_reg == '0) begin
                            quo_reg <= RUN_W'(MAX_RUN_TICKS);
                            phase_reg <= PH_SEND;
                        end else if (ram_rdata.due <= vt_reg) begin
                            quo_reg <= '0;
                            phase_reg <= PH_SEND;
                        end else if (ram_rdata.due - vt_reg >= SPAN) begin
                            quo_reg <= RUN_W'(MAX_RUN_TICKS);
                            phase_reg <= PH_SEND;
                        end else begin
                            promised_reg <= 1'b1;
                            rem_reg <= 31'(ram_rdata.due - vt_reg + NSC - 64'd1);
                            phase_reg <= PH_MUL;
                        end
                    end else if (phase_reg == PH_MUL) begin
                        quo_reg <= RUN_W'(run_prod >> DIV_SH);
                        phase_reg <= PH_SEND;
                    end else if (out_load) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= {3'd0, wd_reg, full_reg, stop_reg, quo_reg, 48'd0};
                        out_user_reg <= 1'b0;
                        out_last_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;
    assign m_axis_tlast = out_last_reg;

    `ASSERT_IMPLY(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_axis_tready)
    `ASSERT_IMPLY(a_count_range, aclk, aresetn, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_fire_unstamped, aclk, aresetn,
        state_reg == ST_FIRE && state_next == ST_SHDN, m_axis_tvalid && m_axis_tuser)
endmodule

// ===== verif/timed_event_queue_with_watchdog_tb.sv =====
// Self-checking testbench for the timed event queue with a no-progress watchdog.
// Depends on teq_pkg and the timed_event_queue_with_watchdog RTL.
module timed_event_queue_with_watchdog_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import teq_pkg::*;

    localparam int          DEPTH    = QUEUE_DEPTH_DEF;
    localparam logic [63:0] NS_CLK   = 64'(NS_PER_CLOCK_DEF);
    localparam logic [63:0] MAX_RUN  = 64'(MAX_RUN_TICKS_DEF);
    localparam int          LONG_HOLD = 400;

    typedef struct {
        req_t        kind;
        logic [31:0] ticks;
        logic        progress;
        logic [31:0] adv;
        logic [31:0] delay;
        logic [31:0] code;
        logic [15:0] tag;
    } request_t;

    typedef struct {
        logic        fired;
        logic [31:0] code;
        logic [15:0] tag;
        logic        last;
        logic [16:0] run;
        logic        stop;
        logic        full;
        logic [1:0]  wd;
    } outcome_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         wr_en = 1'b0;
    logic         wr_index = 1'b0;
    logic [15:0]  wr_data = '0;

    timed_event_queue_with_watchdog dut (.*);

    always #10 aclk = ~aclk;

    // Predictor state.
    logic [63:0] now_ns;
    logic [63:0] due_tab [DEPTH];
    logic [31:0] code_tab [DEPTH];
    logic [15:0] tag_tab [DEPTH];
    int          used;
    logic        promised;
    logic [63:0] wd_deadline;
    logic        wd_warned;
    logic        wd_on;
    logic [15:0] wd_secs;

    request_t pending_q [$];
    outcome_t outcome_q [$];
    bit       failed = 0;
    bit       idling = 1;
    bit       long_hold_req = 0;
    bit       s_taken = 0;
    bit       m_taken = 0;

    // Fire every event that is due, head slot first.
    task automatic fire_due_events();
        outcome_t o;
        while (used > 0 && due_tab[0] <= now_ns) begin
            o = '{1'b1, code_tab[0], tag_tab[0], 1'b0, 17'd0, 1'b0, 1'b0, WD_NONE};
            outcome_q.push_back(o);
            for (int i = 0; i < DEPTH - 1; i++) begin
                due_tab[i] = due_tab[i+1];
                code_tab[i] = code_tab[i+1];
                tag_tab[i] = tag_tab[i+1];
            end
            used--;
            promised = 0;
        end
    endtask

    // Work out every result that one request causes.
    task automatic predict_request(request_t r);
        outcome_t    o;
        logic        stop = 0, full = 0;
        logic [1:0]  wd = WD_NONE;
        logic [63:0] due, span, run;
        int          pos;
        case (r.kind)
            REQ_TICK: begin
                now_ns = now_ns + {32'd0, r.ticks} * NS_CLK;
                fire_due_events();
                if (wd_on) begin
                    if (r.progress) begin
                        wd_deadline = now_ns + {48'd0, wd_secs} * NS_PER_SEC;
                        wd_warned = 0;
                    end else if (now_ns >= wd_deadline) begin
                        wd_deadline = now_ns + {48'd0, wd_secs} * NS_PER_SEC;
                        wd = wd_warned ? WD_LETHAL : WD_CAUTION;
                        wd_warned = !wd_warned;
                    end
                end
            end
            REQ_SCHED: begin
                if (used >= DEPTH) begin
                    full = 1;
                end else begin
                    due = now_ns + {32'd0, r.delay};
                    pos = 0;
                    while (pos < used && !(due < due_tab[pos])) pos++;
                    if (pos < used && pos == 0 && promised) begin
                        stop = 1;
                        promised = 0;
                    end
                    for (int i = used; i > pos; i--) begin
                        due_tab[i] = due_tab[i-1];
                        code_tab[i] = code_tab[i-1];
                        tag_tab[i] = tag_tab[i-1];
                    end
                    due_tab[pos] = due;
                    code_tab[pos] = r.code;
                    tag_tab[pos] = r.tag;
                    used++;
                end
            end
            REQ_IDLE: begin
                now_ns = now_ns + {32'd0, r.adv};
                fire_due_events();
            end
            default: ;
        endcase
        // Run length until the head is due, rounded up and capped.
        span = MAX_RUN * NS_CLK;
        run = MAX_RUN;
        if (used > 0) begin
            if (due_tab[0] <= now_ns) begin
                run = 0;
            end else if (due_tab[0] - now_ns < span) begin
                promised = 1;
                run = (due_tab[0] - now_ns + NS_CLK - 1) / NS_CLK;
            end
        end
        o = '{1'b0, 32'd0, 16'd0, 1'b1, run[16:0], stop, full, wd};
        outcome_q.push_back(o);
    endtask

    // Register write; the predictor takes it at once since the block is idle.
    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge aclk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge aclk);
        wr_en <= 1'b0;
        if (idx == CFG_WD_ENABLE) begin
            wd_on = val[0];
        end else begin
            wd_secs = val;
            wd_deadline = now_ns + {48'd0, wd_secs} * NS_PER_SEC;
        end
    endtask

    task automatic push_req(req_t k, logic [31:0] ticks, logic prog, logic [31:0] adv,
                            logic [31:0] delay, logic [31:0] code, logic [15:0] tag);
        request_t r;
        r = '{k, ticks, prog, adv, delay, code, tag};
        pending_q.push_back(r);
    endtask

    // Mostly schedules and short advances so events really fire; some wide values.
    task automatic push_random(int n);
        request_t r;
        int       pick;
        repeat (n) begin
            pick = $urandom_range(0, 19);
            r.kind = pick < 8 ? REQ_SCHED : pick < 14 ? REQ_TICK : pick < 18 ? REQ_IDLE
                                                                               : REQ_NONE;
            r.ticks = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 200000);
            r.progress = 1'($urandom_range(0, 1));
            r.adv = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 8000000);
            r.delay = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 8000000);
            r.code = $urandom;
            r.tag = 16'($urandom);
            pending_q.push_back(r);
        end
    endtask

    // Wait until the block is idle and nothing is outstanding.
    task automatic drain();
        while (pending_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Request driver: one request at a time, with a random gap after each while idling.
    int tx_gap = 0;
    always @(negedge aclk) begin
        request_t r;
        if (s_axis_tvalid && !s_taken) begin
            // Hold the request until it is taken.
        end else if (tx_gap > 0) begin
            tx_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
            r = pending_q.pop_front();
            s_axis_tdata <= {5'd0, r.tag, r.code, r.delay, r.adv, r.progress, r.ticks, r.kind};
            s_axis_tvalid <= 1'b1;
            tx_gap = idling ? $urandom_range(0, 17) : 0;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver: a random stall per result while idling, and one long hold on demand.
    int  rx_wait = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (long_hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1;
            end
            if (m_taken) rx_wait = idling ? $urandom_range(0, 17) : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge aclk) begin
        request_t r;
        outcome_t e;
        s_taken <= s_axis_tvalid && s_axis_tready;
        m_taken <= m_axis_tvalid && m_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            r.kind = req_t'(s_axis_tdata[1:0]);
            r.ticks = s_axis_tdata[33:2];
            r.progress = s_axis_tdata[34];
            r.adv = s_axis_tdata[66:35];
            r.delay = s_axis_tdata[98:67];
            r.code = s_axis_tdata[130:99];
            r.tag = s_axis_tdata[146:131];
            predict_request(r);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result: tdata %h", m_axis_tdata);
                failed = 1;
            end else begin
                e = outcome_q.pop_front();
                if (m_axis_tuser !== e.fired) begin
                    $error("event_fired: expected %0d, got %0d", e.fired, m_axis_tuser);
                    failed = 1;
                end
                if (m_axis_tdata[31:0] !== e.code) begin
                    $error("fired_code: expected %h, got %h", e.code, m_axis_tdata[31:0]);
                    failed = 1;
                end
                if (m_axis_tdata[47:32] !== e.tag) begin
                    $error("fired_tag: expected %h, got %h", e.tag, m_axis_tdata[47:32]);
                    failed = 1;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                    failed = 1;
                end
                if (m_axis_tdata[64:48] !== e.run) begin
                    $error("run_ticks: expected %0d, got %0d", e.run, m_axis_tdata[64:48]);
                    failed = 1;
                end
                if (m_axis_tdata[65] !== e.stop) begin
                    $error("stop_cpu: expected %0d, got %0d", e.stop, m_axis_tdata[65]);
                    failed = 1;
                end
                if (m_axis_tdata[66] !== e.full) begin
                    $error("queue_full: expected %0d, got %0d", e.full, m_axis_tdata[66]);
                    failed = 1;
                end
                if (m_axis_tdata[68:67] !== e.wd) begin
                    $error("watchdog_status: expected %0d, got %0d", e.wd,
                           m_axis_tdata[68:67]);
                    failed = 1;
                end
            end
        end
    end

    // Run limit.
    initial begin
        #60ms;
        $display("FAIL timed_event_queue_with_watchdog");
        $finish;
    end

    // Stimulus phases.
    initial begin
        now_ns = 0;
        used = 0;
        promised = 0;
        wd_deadline = 0;
        wd_warned = 0;
        wd_on = 0;
        wd_secs = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed: extremes, every request kind, ties, preemption.
        push_req(REQ_TICK, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0, 16'd0);
        push_req(REQ_IDLE, 32'd0, 1'b1, 32'd0, 32'd0, 32'd0, 16'd0);
        push_req(REQ_NONE, '1, 1'b1, '1, '1, '1, '1);
        push_req(REQ_SCHED, 32'd0, 1'b0, 32'd0, 32'd0, '1, '1);
        push_req(REQ_SCHED, 32'd0, 1'b0, 32'd0, 32'd100, 32'hA, 16'h1);
        push_req(REQ_SCHED, 32'd0, 1'b0, 32'd0, 32'd100, 32'hB, 16'h2);
        push_req(REQ_IDLE, 32'd0, 1'b0, 32'd100, 32'd0, 32'd0, 16'd0);
        push_req(REQ_SCHED, 32'd0, 1'b0, 32'd0, 32'd1000, 32'hC, 16'h3);
        push_req(REQ_TICK, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0, 16'd0);
        push_req(REQ_SCHED, 32'd0, 1'b0, 32'd0, 32'd500, 32'hD, 16'h4);
        push_req(REQ_SCHED, 32'd0, 1'b0, 32'd0, 32'd500, 32'hE, 16'h5);
        push_req(REQ_TICK, 32'd100, 1'b1, 32'd0, 32'd0, 32'd0, 16'd0);
        for (int i = 0; i < 13; i++)
            push_req(REQ_SCHED, 32'd0, 1'b0, 32'd0, '1, $urandom, 16'($urandom));
        push_req(REQ_SCHED, 32'd0, 1'b0, 32'd0, 32'd5, 32'hF, 16'h6);
        push_req(REQ_IDLE, 32'd0, 1'b0, '1, 32'd0, 32'd0, 16'd0);
        push_req(REQ_TICK, '1, 1'b1, 32'd0, 32'd0, 32'd0, 16'd0);
        drain();

        // Watchdog on with a one second timeout.
        write_reg(CFG_WD_ENABLE, 16'd1);
        write_reg(CFG_WD_TIMEOUT, 16'd1);
        push_random(120);
        drain();

        // Zero timeout, no idling, and one long receiver hold to fill the block.
        write_reg(CFG_WD_TIMEOUT, 16'd0);
        idling = 0;
        long_hold_req = 1;
        push_random(120);
        drain();
        idling = 1;

        // Largest timeout.
        write_reg(CFG_WD_TIMEOUT, 16'hFFFF);
        push_random(120);
        drain();

        // Watchdog off again.
        write_reg(CFG_WD_ENABLE, 16'd0);
        write_reg(CFG_WD_TIMEOUT, 16'd2);
        push_random(120);
        drain();
        repeat (200) @(posedge aclk);

        if (!failed && outcome_q.size() == 0) begin
            $display("PASS timed_event_queue_with_watchdog");
        end else begin
            $display("FAIL timed_event_queue_with_watchdog");
        end
        $finish;
    end
endmodule
